// ===== hw/rtl/cartridge_chunk_walker_defines.svh =====
// Assertion helpers for the checker file of the chunk walker.
`ifndef CARTRIDGE_CHUNK_WALKER_DEFINES_SVH
`define CARTRIDGE_CHUNK_WALKER_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define CCW_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define CCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ccw_pkg.sv =====
package ccw_pkg;

   localparam int OFFSET_BITS_DEFAULT = 24;

   localparam int BYTE_W        = 8;
   localparam int MAX_SIZE_W    = 24;
   localparam int DATA_OFFSET_W = 24;
   localparam int LOAD_ADDR_W   = 24;
   localparam int LENGTH_W      = 16;
   localparam int KIND_W        = 5;
   localparam int BANK_W        = 3;

   localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = 24'hA0_0000;
   localparam logic [31:0] VALID_TYPE_MASK = 32'h0007_F67E;
   localparam int MIN_SIZE_REJECT = 255;

   // Output queue depth; one input byte yields at most two records.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Result tdata layout, lowest bit first.
   localparam int RSP_TDATA_W  = 80;
   localparam int ACCEPTED_BIT = 72;

   typedef enum logic [1:0] {
      REC_SECTION = 2'd0,
      REC_INVALID = 2'd1,
      REC_VERDICT = 2'd2
   } rec_kind_type;

   typedef struct packed {
      rec_kind_type               record_kind;
      logic [KIND_W-1:0]          chunk_kind;
      logic [BANK_W-1:0]          bank;
      logic [DATA_OFFSET_W-1:0]   data_offset;
      logic [LENGTH_W-1:0]        data_length;
      logic [LOAD_ADDR_W-1:0]     load_address;
      logic                       accepted;
      logic                       run_end;
   } rec_type;

   // Records produced by one processed byte, in delivery order.
   typedef struct packed {
      logic    push0;
      logic    push1;
      rec_type rec0;
      rec_type rec1;
   } push_type;

   // Load address of a known chunk type; types without a fixed address
   // load at their data offset.
   function automatic logic [LOAD_ADDR_W-1:0] load_address_of(
      input logic [KIND_W-1:0]        kind,
      input logic [DATA_OFFSET_W-1:0] offset
   );
      logic [LOAD_ADDR_W-1:0] addr;
      case (kind)
         5'd1:    addr = 24'h00_4000;
         5'd2:    addr = 24'h00_6000;
         5'd4:    addr = 24'h00_8000;
         5'd6:    addr = 24'h01_4404;
         5'd9:    addr = 24'h01_00E4;
         5'd10:   addr = 24'h00_FFE4;
         5'd12:   addr = 24'h00_3FC0;
         5'd14:   addr = 24'h01_3E64;
         5'd15:   addr = 24'h01_1164;
         default: addr = offset;
      endcase
      return addr;
   endfunction

endpackage

// ===== hw/rtl/ccw_walker.sv =====
module ccw_walker
   import ccw_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_byte,
   input  logic                  req_last,
   input  logic                  csr_wr_en,
   input  logic [MAX_SIZE_W-1:0] csr_wr_data,
   input  logic                  room,
   output push_type              push
);

   localparam int CMP_W = (OFFSET_BITS > MAX_SIZE_W) ? OFFSET_BITS : MAX_SIZE_W;
   localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [5:0] {
      PH_HEADER   = 6'b000001,
      PH_LEN_LO   = 6'b000010,
      PH_LEN_HI   = 6'b000100,
      PH_RESERVED = 6'b001000,
      PH_DATA     = 6'b010000,
      PH_DEAD     = 6'b100000
   } phase_type;

   logic                    in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]       in_byte_ff;
   logic                    in_last_ff;
   logic [MAX_SIZE_W-1:0]   max_size_ff, max_size_in;
   phase_type               phase_ff, phase_in;
   logic [OFFSET_BITS-1:0]  byte_count_ff, byte_count_in;
   logic [LENGTH_W-1:0]     skip_left_ff, skip_left_in;
   logic [KIND_W-1:0]       held_kind_ff, held_kind_in;
   logic [BANK_W-1:0]       held_bank_ff, held_bank_in;
   logic [BYTE_W-1:0]       length_low_ff, length_low_in;
   logic                    failed_ff, failed_in;

   logic                    fire;
   logic                    accept;
   logic [OFFSET_BITS:0]    off_sum;
   logic [OFFSET_BITS-1:0]  off_sat;
   logic [DATA_OFFSET_W-1:0] off_out;
   logic [LENGTH_W-1:0]     length_full;
   logic [LENGTH_W-1:0]     skip_dec;
   logic [CMP_W-1:0]        count_cmp;
   logic                    size_ok;
   logic                    verdict_ok;
   rec_type                 chunk_rec;
   logic                    chunk_rec_valid;
   rec_type                 verdict_rec;

   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;
   assign accept     = req_tvalid && req_tready;

   assign off_sum     = {1'b0, byte_count_ff} + (OFFSET_BITS + 1)'(2);
   assign off_sat     = off_sum[OFFSET_BITS] ? COUNT_MAX : off_sum[OFFSET_BITS-1:0];
   assign off_out     = DATA_OFFSET_W'(off_sat);
   assign length_full = {in_byte_ff, length_low_ff};
   assign skip_dec    = (skip_left_ff != '0) ? skip_left_ff - 1'b1 : skip_left_ff;

   always_comb begin
      in_valid_in   = in_valid_ff;
      max_size_in   = csr_wr_en ? csr_wr_data : max_size_ff;
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      skip_left_in  = skip_left_ff;
      held_kind_in  = held_kind_ff;
      held_bank_in  = held_bank_ff;
      length_low_in = length_low_ff;
      failed_in     = failed_ff;

      chunk_rec       = '0;
      chunk_rec_valid = 1'b0;
      verdict_rec     = '0;
      count_cmp       = '0;
      size_ok         = 1'b0;
      verdict_ok      = 1'b0;

      if (fire) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
      end

      if (fire) begin
         if (byte_count_ff != COUNT_MAX) begin
            byte_count_in = byte_count_ff + 1'b1;
         end

         case (phase_ff)
            PH_HEADER: begin
               held_kind_in = in_byte_ff[KIND_W-1:0];
               held_bank_in = in_byte_ff[BYTE_W-1:KIND_W];
               phase_in     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_low_in = in_byte_ff;
               phase_in      = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               chunk_rec_valid          = 1'b1;
               chunk_rec.chunk_kind     = held_kind_ff;
               chunk_rec.bank           = held_bank_ff;
               chunk_rec.data_offset    = off_out;
               chunk_rec.data_length    = length_full;
               if (VALID_TYPE_MASK[held_kind_ff]) begin
                  chunk_rec.record_kind  = REC_SECTION;
                  chunk_rec.load_address = load_address_of(held_kind_ff, off_out);
                  skip_left_in           = length_full;
                  phase_in               = PH_RESERVED;
               end else begin
                  chunk_rec.record_kind = REC_INVALID;
                  failed_in             = 1'b1;
                  phase_in              = PH_DEAD;
               end
            end
            PH_RESERVED: begin
               phase_in = (skip_left_ff == '0) ? PH_HEADER : PH_DATA;
            end
            PH_DATA: begin
               skip_left_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               phase_in = PH_DEAD;
            end
         endcase

         if (in_last_ff) begin
            // The verdict sees the count and phase after this byte.
            count_cmp  = CMP_W'(byte_count_in);
            size_ok    = (count_cmp > CMP_W'(MIN_SIZE_REJECT)) &&
                         (count_cmp <= CMP_W'(max_size_ff));
            verdict_ok = size_ok && (phase_in != PH_LEN_LO) &&
                         (phase_in != PH_LEN_HI) && !failed_in;
            verdict_rec.record_kind = REC_VERDICT;
            verdict_rec.accepted    = verdict_ok;
            verdict_rec.run_end     = 1'b1;

            phase_in      = PH_HEADER;
            byte_count_in = '0;
            skip_left_in  = '0;
            held_kind_in  = '0;
            held_bank_in  = '0;
            length_low_in = '0;
            failed_in     = 1'b0;
         end else begin
            chunk_rec.run_end = 1'b1;
         end
      end
   end

   always_comb begin
      push = '0;
      if (chunk_rec_valid) begin
         push.push0 = 1'b1;
         push.rec0  = chunk_rec;
         push.push1 = fire && in_last_ff;
         push.rec1  = verdict_rec;
      end else if (fire && in_last_ff) begin
         push.push0 = 1'b1;
         push.rec0  = verdict_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         max_size_ff   <= MAX_SIZE_RESET;
         phase_ff      <= PH_HEADER;
         byte_count_ff <= '0;
         skip_left_ff  <= '0;
         held_kind_ff  <= '0;
         held_bank_ff  <= '0;
         length_low_ff <= '0;
         failed_ff     <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         max_size_ff   <= max_size_in;
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         skip_left_ff  <= skip_left_in;
         held_kind_ff  <= held_kind_in;
         held_bank_ff  <= held_bank_in;
         length_low_ff <= length_low_in;
         failed_ff     <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_byte;
         in_last_ff <= req_last;
      end
   end

endmodule

// ===== hw/rtl/ccw_out_queue.sv =====
module ccw_out_queue
   import ccw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rec_type  rsp_rec
);

   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] wr_ptr_next;
   logic [QUEUE_PTR_W:0]   push_count;
   logic                   pop;
   rec_type                entry_ff [QUEUE_DEPTH];

   // Room is judged on the current fill so a byte with two records always fits.
   assign room        = count_ff <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH - 2);
   assign rsp_valid   = count_ff != '0;
   assign rsp_rec     = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign push_count  = (QUEUE_PTR_W + 1)'(push.push0) + (QUEUE_PTR_W + 1)'(push.push1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + push_count - (QUEUE_PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         entry_ff[wr_ptr_ff] <= push.rec0;
      end
      if (push.push1) begin
         entry_ff[wr_ptr_next] <= push.rec1;
      end
   end

endmodule

// ===== hw/rtl/cartridge_chunk_walker.sv =====
// Cartridge chunk walker. Feed the cartridge image one byte per request on the
// req_ channel, with req_tlast high on its last byte. Each chunk is a header
// byte (bank in bits 7..5, type in bits 4..0), a little-endian 16-bit length,
// a reserved byte and that many data bytes, which are skipped. When the length
// high byte arrives the block returns a section record (known type, with its
// data offset, length and load address) or an invalid-chunk record (unknown
// type, after which the rest of the image is only counted). The last byte adds
// a verdict record; rsp_tlast marks the last record caused by one byte. The
// byte counter saturates at 2^OFFSET_BITS-1. The block takes one byte per
// clock cycle while the queue has room: the request enters an input register,
// the chunk state and records are formed combinationally behind it, and
// records leave through a four-entry queue at one per cycle while rsp_tready
// is high. A record passes the input register and a queue entry before it
// shows on rsp_; a byte with two records (a section and the verdict) writes
// both into the queue together. The user must write max_size through csr_wr_en
// / csr_wr_data only while the block is idle; the block does not enforce this.
module cartridge_chunk_walker
   import ccw_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   // Request channel: one image byte.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] data_byte
   input  logic                   req_tlast,   // final_byte

   // Result channel: one record.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [4:0] chunk_kind, [7:5] bank, [31:8] data_offset, [47:32] data_length,
   // [71:48] load_address, [72] accepted, [79:73] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]             rsp_tuser,   // [1:0] record_kind
   output logic                   rsp_tlast,   // run_end

   // Configuration: max_size.
   input  logic                   csr_wr_en,
   input  logic [MAX_SIZE_W-1:0]  csr_wr_data
);

   push_type push;
   logic     room;
   rec_type  rsp_rec;

   // Chunk state machine behind the input register.
   ccw_walker #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_byte    (req_tdata),
      .req_last    (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .room        (room),
      .push        (push)
   );

   // Result queue; its head register drives the result channel directly.
   ccw_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_rec   (rsp_rec)
   );

   assign rsp_tdata = {7'b0, rsp_rec.accepted, rsp_rec.load_address,
                       rsp_rec.data_length, rsp_rec.data_offset,
                       rsp_rec.bank, rsp_rec.chunk_kind};
   assign rsp_tuser = rsp_rec.record_kind;
   assign rsp_tlast = rsp_rec.run_end;

endmodule

// ===== hw/rtl/ccw_checker.sv =====
`include "cartridge_chunk_walker_defines.svh"

module ccw_checker
   import ccw_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]             rsp_tuser,
   input logic                   rsp_tlast
);

   // A stalled record holds still.
   `CCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result changed while stalled")

   // A verdict is always the last record of its byte.
   `CCW_ASSERT_IMPLY(a_verdict_last, clock, reset, rsp_tvalid && (rsp_tuser == REC_VERDICT), rsp_tlast, "verdict without run end")

   // Only a verdict carries the accepted flag.
   `CCW_ASSERT_IMPLY(a_accept_only_verdict, clock, reset, rsp_tvalid && (rsp_tuser != REC_VERDICT), !rsp_tdata[ACCEPTED_BIT], "accepted set outside a verdict")

   // Reset empties the result queue.
   `CCW_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid right after reset")

endmodule

bind cartridge_chunk_walker ccw_checker u_ccw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
